// ===== rtl/dbtgd_pkg.sv =====
package dbtgd_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned PenW     = 15;
  localparam int unsigned NumW     = 15;
  localparam int unsigned DrawW    = 16;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic [PenW-1:0] PenMax = 15'h7fff;

  localparam logic [CodeW-1:0] SjisLoA   = 8'h81;
  localparam logic [CodeW-1:0] SjisHiA   = 8'h9f;
  localparam logic [CodeW-1:0] SjisLoB   = 8'he0;
  localparam logic [CodeW-1:0] SjisHiB   = 8'hfc;
  localparam logic [CodeW-1:0] EucLeadLo = 8'h81;
  localparam logic [CodeW-1:0] EucLeadHi = 8'hfe;
  localparam logic [CodeW-1:0] TrailLoA  = 8'h40;
  localparam logic [CodeW-1:0] TrailHiA  = 8'h7e;
  localparam logic [CodeW-1:0] TrailLoB  = 8'h80;
  localparam logic [CodeW-1:0] TrailHiB  = 8'h9e;

  typedef enum logic [1:0] {
    LangAscii = 2'd0,
    LangSjis  = 2'd1,
    LangEuc   = 2'd2,
    LangOff   = 2'd3
  } lang_mode_e;

  typedef enum logic [1:0] {
    GlyphNone = 2'd0,
    GlyphAscii = 2'd1,
    GlyphHalf = 2'd2,
    GlyphFull = 2'd3
  } glyph_kind_e;

  localparam logic [CfgIdxW-1:0] CfgLangMode = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgScale    = 8'd1;

  typedef struct packed {
    logic [PenW-1:0]  start_x;
    logic             new_string;
    logic [CodeW-1:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [DrawW-1:0] draw_x;
    logic signed [NumW-1:0]  glyph_number;
    glyph_kind_e             glyph_kind;
  } out_item_t;

endpackage

// ===== rtl/double_byte_text_glyph_decoder.sv =====
// Channel  | Signals                                      | Content
// s_axis   | s_axis_tvalid/tready/tdata/tuser             | text byte transaction in
// m_axis   | m_axis_tvalid/tready/tdata/tuser             | glyph request transaction out
// cfg      | cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i | register write
//
// Two register stages: input register, then decode into the result register.
// One byte per cycle unless m_axis stalls; the result register drives m_axis_tvalid.
// The decode cone (row*94 multiply by constant, pen add and saturate) sets timing.
// Reset clears valids, held lead byte, pen, mode (ASCII) and scale (1).
// A stall on m_axis holds the result; the input register still fills once.
module double_byte_text_glyph_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] code_byte, [22:8] start_x, [23] zero
  input  logic [dbtgd_pkg::InDataW-1:0] s_axis_tdata,
  // [0] new_string
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [14:0] glyph_number, [30:15] draw_x, [31] zero
  output logic [dbtgd_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] glyph_kind
  output logic [1:0]                    m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbtgd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dbtgd_pkg::CfgDataW-1:0] cfg_data_i
);
  import dbtgd_pkg::*;

  lang_mode_e          mode_q;
  logic [ScaleW-1:0]   scale_q;
  logic [CodeW-1:0]    lead_q, lead_d;
  logic [PenW-1:0]     pen_q, pen_d;
  logic                in_valid_q, out_valid_q;
  in_item_t            in_q;
  out_item_t           out_q, out_d;
  logic                out_ready, in_ready;

  assign cfg_ready_o   = 1'b1;
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.draw_x, out_q.glyph_number};
  assign m_axis_tuser  = out_q.glyph_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= LangAscii;
      scale_q <= ScaleW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgLangMode) mode_q <= lang_mode_e'(cfg_data_i[1:0]);
      else if (cfg_index_i == CfgScale) scale_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q.code_byte  <= s_axis_tdata[CodeW-1:0];
      in_q.start_x    <= s_axis_tdata[CodeW+PenW-1:CodeW];
      in_q.new_string <= s_axis_tuser;
    end
  end

  logic [PenW-1:0]        pen_cur;
  logic [PenW:0]          pen_sum;
  logic [CodeW-1:0]       b;
  logic                   is_lead;
  logic signed [15:0]     lead_s, byte_s, k, t, idx;

  always_comb begin
    b        = in_q.code_byte;
    pen_cur  = in_q.new_string ? in_q.start_x : pen_q;
    pen_sum  = {1'b0, pen_cur} + (PenW+1)'({scale_q, 3'b000});
    lead_s   = signed'({8'd0, lead_q});
    byte_s   = signed'({8'd0, b});
    k        = '0;
    t        = '0;
    if (mode_q == LangSjis) begin
      if (lead_q >= SjisLoA && lead_q <= SjisHiA) k = (lead_s - 16'sh81) <<< 1;
      else k = ((lead_s - 16'she0) <<< 1) + 16'sd62;
      if (b >= TrailLoA && b <= TrailHiA) begin
        t = byte_s - 16'sh40;
      end else if (b >= TrailLoB && b <= TrailHiB) begin
        t = byte_s - 16'sh80 + 16'sd63;
      end else begin
        t = byte_s - 16'sh9f;
        k = k + 16'sd1;
      end
    end else begin
      k = lead_s - 16'sha1;
      t = byte_s - 16'sha1;
    end
    idx = 16'(k * 16'sd94) + t;

    if (mode_q == LangSjis)
      is_lead = (b >= SjisLoA && b <= SjisHiA) || (b >= SjisLoB && b <= SjisHiB);
    else
      is_lead = (b >= EucLeadLo && b <= EucLeadHi);

    lead_d             = lead_q;
    out_d.glyph_kind   = GlyphNone;
    out_d.glyph_number = '0;
    out_d.draw_x       = '0;
    case (mode_q)
      LangAscii: begin
        out_d.glyph_kind   = GlyphAscii;
        out_d.glyph_number = signed'(NumW'(b));
        out_d.draw_x       = signed'({1'b0, pen_cur});
      end
      LangSjis, LangEuc: begin
        if (lead_q == '0) begin
          if (is_lead) begin
            lead_d = b;
          end else begin
            out_d.glyph_kind   = GlyphHalf;
            out_d.glyph_number = signed'(NumW'(b));
            out_d.draw_x       = signed'({1'b0, pen_cur});
          end
        end else begin
          lead_d             = '0;
          out_d.glyph_kind   = GlyphFull;
          out_d.glyph_number = signed'(idx[NumW-1:0]);
          out_d.draw_x       = signed'({1'b0, pen_cur} - DrawW'(8));
        end
      end
      default: ;
    endcase

    if (mode_q == LangOff) pen_d = pen_cur;
    else if (pen_sum[PenW]) pen_d = PenMax;
    else pen_d = pen_sum[PenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lead_q      <= '0;
      pen_q       <= '0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        lead_q <= lead_d;
        pen_q  <= pen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) out_q <= out_d;
  end

endmodule
